// ===== rtl/edid_block_field_parser_macros.svh =====
// Assertion macros for the identification block parser.
// Used by the top level only; needs no other file.
`ifndef EDID_BLOCK_FIELD_PARSER_MACROS_SVH
`define EDID_BLOCK_FIELD_PARSER_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define EBFP_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("ebfp: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define EBFP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ebfp: implication violated");

`endif

// ===== rtl/ebfp_pkg.sv =====
// Shared types and constants for the identification block parser.
// No dependencies; every module of the block imports it.
package ebfp_pkg;

   // block layout
   localparam int HEADER_LEN       = 8;
   localparam int DESC_START       = 54;
   localparam int DESC_SIZE        = 18;
   localparam int DESCRIPTOR_COUNT = 4;
   localparam int DESC_END         = DESC_START + DESC_SIZE * DESCRIPTOR_COUNT;
   localparam int POS_SAT          = 128;
   localparam int TEXT_LEN         = 13;
   localparam int TEXT_FIRST_OFF   = 5;
   localparam int TAG_OFF          = 3;

   // capture offsets
   localparam int POS_VENDOR_HI  = 8;
   localparam int POS_VENDOR_LO  = 9;
   localparam int POS_PRODUCT_LO = 10;
   localparam int POS_PRODUCT_HI = 11;
   localparam int POS_SERIAL_0   = 12;
   localparam int POS_SERIAL_1   = 13;
   localparam int POS_SERIAL_2   = 14;
   localparam int POS_SERIAL_3   = 15;
   localparam int POS_WEEK       = 16;
   localparam int POS_YEAR       = 17;
   localparam int POS_MAJOR      = 18;
   localparam int POS_MINOR      = 19;

   localparam logic [31:0] SERIAL_UNSET = 32'h0101_0101;
   localparam logic [11:0] YEAR_BASE    = 12'd1990;
   localparam logic [7:0]  TEXT_END     = 8'h0A;
   localparam logic [7:0]  TAG_NAME     = 8'hFC;
   localparam logic [7:0]  TAG_SERIAL   = 8'hFF;
   localparam logic [7:0]  TAG_ASCII    = 8'hFE;
   localparam logic [7:0]  HDR_FILL     = 8'hFF;
   localparam logic [7:0]  HDR_EDGE     = 8'h00;

   localparam int RSP_FIFO_DEPTH = 4;

   typedef enum logic [1:0] {
      KIND_NAME    = 2'd0,
      KIND_SERIAL  = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_HEADER_BAD   = 2'd1,
      STATUS_CHECKSUM_BAD = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      TEXT_NONE   = 2'd0,
      TEXT_NAME   = 2'd1,
      TEXT_SERIAL = 2'd2
   } text_type;

   // one accepted input byte held in the input register
   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       last_byte;
   } ebfp_req_type;

   typedef struct packed {
      kind_type    result_kind;
      logic [11:0] year;
      logic [7:0]  week;
      logic        serial_set;
      logic [31:0] serial_number;
      logic [15:0] product_code;
      logic [14:0] vendor_id;
      logic [7:0]  version_minor;
      logic [7:0]  version_major;
      status_type  block_status;
      logic [3:0]  text_index;
      logic [7:0]  text_char;
   } rsp_item_type;

   // results of one byte: count is 0, 1 or 2; item_a goes first
   typedef struct packed {
      logic [1:0]   count;
      rsp_item_type item_a;
      rsp_item_type item_b;
   } ebfp_push_type;

endpackage

// ===== rtl/ebfp_in_stage.sv =====
// Input register for the parser: holds one accepted byte until the parser takes it.
// Depends on ebfp_pkg.
module ebfp_in_stage
   import ebfp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tlast,
   input  logic         take,
   output ebfp_req_type req_out
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   // register is free when empty or drained this cycle
   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_tdata;
         last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign req_out.valid     = valid_ff;
   assign req_out.data_byte = byte_ff;
   assign req_out.last_byte = last_ff;

endmodule

// ===== rtl/ebfp_parse.sv =====
// Per-byte parser: header check, checksum, field capture, descriptor text.
// Depends on ebfp_pkg. Produces up to two results per byte.
module ebfp_parse
   import ebfp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ebfp_req_type  req_in,
   input  logic          room,
   output logic          take,
   output ebfp_push_type push
);

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic        nz_ff, nz_in;
   logic        hdr_ff, hdr_in;
   logic [15:0] vendor_ff, vendor_in;
   logic [15:0] product_ff, product_in;
   logic [31:0] serial_ff, serial_in;
   logic [7:0]  week_ff, week_in;
   logic [7:0]  yearb_ff, yearb_in;
   logic [7:0]  major_ff, major_in;
   logic [7:0]  minor_ff, minor_in;
   logic        head_zero_ff, head_zero_in;
   logic [4:0]  off_ff, off_in;
   text_type    text_ff, text_in;
   logic [3:0]  cnt_ff, cnt_in;

   logic         fire;
   logic [7:0]   b;
   logic         in_desc;
   logic         emit;
   logic         hdr_ok;
   logic         sum_ok;
   rsp_item_type chr;
   rsp_item_type summ;

   assign fire = req_in.valid && room;
   assign take = fire;
   assign b    = req_in.data_byte;
   assign in_desc = (pos_ff >= 8'(DESC_START)) && (pos_ff < 8'(DESC_END));

   // next state for one byte
   always_comb begin
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      nz_in        = nz_ff;
      hdr_in       = hdr_ff;
      vendor_in    = vendor_ff;
      product_in   = product_ff;
      serial_in    = serial_ff;
      week_in      = week_ff;
      yearb_in     = yearb_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      head_zero_in = head_zero_ff;
      off_in       = off_ff;
      text_in      = text_ff;
      cnt_in       = cnt_ff;
      emit         = 1'b0;
      if (fire) begin
         sum_in = sum_ff + b;
         nz_in  = nz_ff || (b != 8'd0);

         // header bytes and fixed-offset captures
         if (pos_ff < 8'(HEADER_LEN)) begin
            if (pos_ff == 8'd0 || pos_ff == 8'(HEADER_LEN - 1)) begin
               if (b != HDR_EDGE) hdr_in = 1'b0;
            end else begin
               if (b != HDR_FILL) hdr_in = 1'b0;
            end
         end else begin
            unique case (pos_ff)
               8'(POS_VENDOR_HI):  vendor_in[15:8]   = b;
               8'(POS_VENDOR_LO):  vendor_in[7:0]    = b;
               8'(POS_PRODUCT_LO): product_in[7:0]   = b;
               8'(POS_PRODUCT_HI): product_in[15:8]  = b;
               8'(POS_SERIAL_0):   serial_in[7:0]    = b;
               8'(POS_SERIAL_1):   serial_in[15:8]   = b;
               8'(POS_SERIAL_2):   serial_in[23:16]  = b;
               8'(POS_SERIAL_3):   serial_in[31:24]  = b;
               8'(POS_WEEK):       week_in           = b;
               8'(POS_YEAR):       yearb_in          = b;
               8'(POS_MAJOR):      major_in          = b;
               8'(POS_MINOR):      minor_in          = b;
               default: ;
            endcase
         end

         // descriptor slots
         if (in_desc) begin
            off_in = (off_ff == 5'(DESC_SIZE - 1)) ? 5'd0 : off_ff + 5'd1;
            if (off_ff == 5'd0) begin
               head_zero_in = (b == 8'd0);
               text_in      = TEXT_NONE;
               cnt_in       = 4'd0;
            end else if (off_ff < 5'(TAG_OFF)) begin
               head_zero_in = head_zero_ff && (b == 8'd0);
            end else if (off_ff == 5'(TAG_OFF)) begin
               text_in = TEXT_NONE;
               if (head_zero_ff && hdr_ff) begin
                  if (b == TAG_NAME) text_in = TEXT_NAME;
                  else if (b == TAG_SERIAL || b == TAG_ASCII) text_in = TEXT_SERIAL;
               end
            end else if (off_ff >= 5'(TEXT_FIRST_OFF) && text_ff != TEXT_NONE) begin
               if (b == TEXT_END) begin
                  text_in = TEXT_NONE;
               end else if (cnt_ff < 4'(TEXT_LEN)) begin
                  emit   = 1'b1;
                  cnt_in = cnt_ff + 4'd1;
                  if (cnt_ff + 4'd1 >= 4'(TEXT_LEN)) text_in = TEXT_NONE;
               end
            end
         end

         if (pos_ff < 8'(POS_SAT)) pos_in = pos_ff + 8'd1;
      end
   end

   // character result
   always_comb begin
      chr             = '0;
      chr.result_kind = (text_ff == TEXT_NAME) ? KIND_NAME : KIND_SERIAL;
      chr.text_char   = b;
      chr.text_index  = cnt_ff;
      chr.block_status = STATUS_OK;
   end

   // summary result, built from the state after this byte
   assign hdr_ok = hdr_in && (pos_ff >= 8'(HEADER_LEN - 1));
   assign sum_ok = nz_in && (sum_in == 8'd0);

   always_comb begin
      summ             = '0;
      summ.result_kind = KIND_SUMMARY;
      if (!hdr_ok) begin
         summ.block_status = STATUS_HEADER_BAD;
      end else begin
         summ.block_status  = sum_ok ? STATUS_OK : STATUS_CHECKSUM_BAD;
         summ.version_major = major_in;
         summ.version_minor = minor_in;
         summ.vendor_id     = vendor_in[14:0];
         summ.product_code  = product_in;
         summ.serial_number = serial_in;
         summ.serial_set    = (serial_in != 32'd0) && (serial_in != SERIAL_UNSET);
         summ.week          = week_in;
         summ.year          = 12'(yearb_in) + YEAR_BASE;
      end
   end

   // pack results, char first
   always_comb begin
      push        = '0;
      push.count  = {1'b0, emit && fire} + {1'b0, fire && req_in.last_byte};
      push.item_a = emit ? chr : summ;
      push.item_b = summ;
   end

   // state registers; the last byte returns everything to reset values
   always_ff @(posedge clock) begin
      if (reset || (fire && req_in.last_byte)) begin
         pos_ff       <= '0;
         sum_ff       <= '0;
         nz_ff        <= 1'b0;
         hdr_ff       <= 1'b1;
         vendor_ff    <= '0;
         product_ff   <= '0;
         serial_ff    <= '0;
         week_ff      <= '0;
         yearb_ff     <= '0;
         major_ff     <= '0;
         minor_ff     <= '0;
         head_zero_ff <= 1'b0;
         off_ff       <= '0;
         text_ff      <= TEXT_NONE;
         cnt_ff       <= '0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         nz_ff        <= nz_in;
         hdr_ff       <= hdr_in;
         vendor_ff    <= vendor_in;
         product_ff   <= product_in;
         serial_ff    <= serial_in;
         week_ff      <= week_in;
         yearb_ff     <= yearb_in;
         major_ff     <= major_in;
         minor_ff     <= minor_in;
         head_zero_ff <= head_zero_in;
         off_ff       <= off_in;
         text_ff      <= text_in;
         cnt_ff       <= cnt_in;
      end
   end

endmodule

// ===== rtl/ebfp_rsp_fifo.sv =====
// Result queue: takes up to two results per cycle, hands out one per cycle while popped.
// Depends on ebfp_pkg.
module ebfp_rsp_fifo
   import ebfp_pkg::*;
#(
   parameter int DEPTH = RSP_FIFO_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  ebfp_push_type                push,
   input  logic                         pop,
   output rsp_item_type                 head,
   output logic [$clog2(DEPTH+1)-1:0]   fill
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rsp_item_type     entry_ff [DEPTH];
   rsp_item_type     entry_in [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, wr_nxt, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
      return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_nxt = bump(wr_ff);
   assign head   = entry_ff[rd_ff];
   assign fill   = cnt_ff;

   // entry writes
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
         if (push.count != 2'd0 && wr_ff == PW'(i)) entry_in[i] = push.item_a;
         if (push.count == 2'd2 && wr_nxt == PW'(i)) entry_in[i] = push.item_b;
      end
   end

   // pointers and count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      if (push.count == 2'd1) wr_in = wr_nxt;
      else if (push.count == 2'd2) wr_in = bump(wr_nxt);
      if (pop) rd_in = bump(rd_ff);
      cnt_in = cnt_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
   end

endmodule

// ===== rtl/edid_block_field_parser.sv =====
// Identification block parser, top level: input register, parser, result queue.
// Depends on ebfp_pkg, ebfp_in_stage, ebfp_parse, ebfp_rsp_fifo and the macro header.
//
// Usage: bytes of a display-identification block enter on the req_ stream, one
// request per byte from offset 0, with req_tlast on the final byte. Results
// leave on the rsp_ stream: one item per text character of a name or serial
// descriptor (kind in rsp_tuser), and one summary item after the last byte.
// Path: an accepted byte is held in the input register, parsed straight out of
// it when the queue has room, and its results are registered into the queue;
// with an empty queue, rsp_tvalid rises once they are written.
// Throughput: one byte per cycle. A byte gives at most two results (a char and
// the summary); the result queue of RSP_DEPTH entries drains one per cycle with
// rsp_tready high; the parser stalls only when fewer than two entries are free.
// Reset (synchronous, active high) empties the input register and queue and
// starts a new block; the state also clears after each summary.
// A stalled receiver fills the queue, the parser stops, then req_tready drops;
// nothing is lost or repeated.
module edid_block_field_parser
   import ebfp_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_FIFO_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  logic [7:0]     req_tdata,   // [7:0] data_byte
   input  logic           req_tlast,   // last_byte
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // [7:0] text_char, [11:8] text_index, [13:12] block_status,
   // [21:14] version_major, [29:22] version_minor, [44:30] vendor_id,
   // [60:45] product_code, [92:61] serial_number, [93] serial_set,
   // [101:94] week, [113:102] year, [119:114] zero
   output logic [119:0]   rsp_tdata,
   output logic [1:0]     rsp_tuser    // [1:0] result_kind
);

`include "edid_block_field_parser_macros.svh"

   localparam int CW = $clog2(RSP_DEPTH + 1);

   ebfp_req_type  req_q;
   ebfp_push_type push;
   rsp_item_type  head;
   logic          take;
   logic          room;
   logic          pop;
   logic [CW-1:0] fill;
   logic          pair_ordered;

   ebfp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .req_out    (req_q)
   );

   // parser runs only when two queue entries are free
   assign room = (fill <= CW'(RSP_DEPTH - 2));

   ebfp_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .req_in (req_q),
      .room   (room),
      .take   (take),
      .push   (push)
   );

   assign pop = rsp_tvalid && rsp_tready;

   ebfp_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .fill  (fill)
   );

   // result channel
   assign rsp_tvalid = (fill != '0);
   assign rsp_tuser  = head.result_kind;
   assign rsp_tdata  = {6'd0, head.year, head.week, head.serial_set, head.serial_number,
                        head.product_code, head.vendor_id, head.version_minor,
                        head.version_major, head.block_status, head.text_index,
                        head.text_char};

   // a pair is always a char followed by the summary
   assign pair_ordered = (push.item_b.result_kind == KIND_SUMMARY) &&
                         (push.item_a.result_kind != KIND_SUMMARY);

   `EBFP_ASSERT_ALWAYS(a_fill_bound, clock, reset, fill <= CW'(RSP_DEPTH))
   `EBFP_ASSERT_IMPL(a_push_room, clock, reset, push.count != 2'd0, room && req_q.valid)
   `EBFP_ASSERT_IMPL(a_pair_order, clock, reset, push.count == 2'd2, pair_ordered)

endmodule
